// ===== rtl/hbs_pkg.sv =====
// shared types, constants and the divider step for the height map sampler
// no dependencies
package hbs_pkg;

  // map geometry and store size
  localparam int MAP_SIZE    = 256;
  localparam int IDX_W       = $clog2(MAP_SIZE);
  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  // field widths
  localparam int POS_W  = 32;
  localparam int HGT_W  = 16;
  localparam int FRAC_W = 8;
  localparam int WGT_W  = 2 * FRAC_W + 1;
  localparam int CFG_W  = 16;

  // divider pipeline shape
  localparam int DIV_STEPS    = POS_W;
  localparam int STEPS_PER_ST = 2;
  localparam int DIV_STAGES   = DIV_STEPS / STEPS_PER_ST;

  // item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // register indexes
  typedef enum logic {
    REG_CELL_SIZE   = 1'b0,
    REG_HEIGHT_GAIN = 1'b1
  } reg_idx_t;

  // item sideband carried alongside the divider
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [ADDR_W-1:0] idx;
    logic [HGT_W-1:0]  hgt;
  } side_t;

  // what the map stage hands to the blend stages
  typedef struct packed {
    logic                  valid;
    logic                  oor;
    logic [3:0][HGT_W-1:0] h;
    logic [3:0][WGT_W-1:0] w;
  } blend_in_t;

  // one restoring division step: returns {remainder, shifted numerator}
  function automatic logic [CFG_W+POS_W-1:0] div_step(
    input logic [CFG_W-1:0] rem,
    input logic [POS_W-1:0] num,
    input logic [CFG_W-1:0] dvs
  );
    logic [CFG_W:0]   t;
    logic             ge;
    logic [CFG_W-1:0] rem_n;
    t     = {rem, num[POS_W-1]};
    ge    = (t >= {1'b0, dvs});
    rem_n = ge ? CFG_W'(t - {1'b0, dvs}) : t[CFG_W-1:0];
    return {rem_n, num[POS_W-2:0], ge};
  endfunction

endpackage

// ===== rtl/hbs_div_pipe.sv =====
// pipelined restoring divider for x and z by the cell size
// depends on hbs_pkg
module hbs_div_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  hbs_pkg::side_t               side_in,
  input  logic [hbs_pkg::POS_W-1:0]    x_in,
  input  logic [hbs_pkg::POS_W-1:0]    z_in,
  input  logic [hbs_pkg::CFG_W-1:0]    cell_size,
  output hbs_pkg::side_t               side_out,
  output logic [hbs_pkg::POS_W-1:0]    gx,
  output logic [hbs_pkg::POS_W-1:0]    gz
);

  logic [hbs_pkg::CFG_W-1:0] dvs;
  hbs_pkg::side_t            side_r [hbs_pkg::DIV_STAGES];
  logic [hbs_pkg::CFG_W-1:0] rx_r   [hbs_pkg::DIV_STAGES];
  logic [hbs_pkg::CFG_W-1:0] rz_r   [hbs_pkg::DIV_STAGES];
  logic [hbs_pkg::POS_W-1:0] nx_r   [hbs_pkg::DIV_STAGES];
  logic [hbs_pkg::POS_W-1:0] nz_r   [hbs_pkg::DIV_STAGES];

  // zero cell size divides by one
  assign dvs = (cell_size == '0) ? hbs_pkg::CFG_W'(1) : cell_size;

  for (genvar s = 0; s < hbs_pkg::DIV_STAGES; s++) begin : g_stg
    logic [hbs_pkg::CFG_W-1:0] rx_nxt, rz_nxt;
    logic [hbs_pkg::POS_W-1:0] nx_nxt, nz_nxt;

    // two quotient bits per stage
    always_comb begin
      if (s == 0) begin
        rx_nxt = '0;
        rz_nxt = '0;
        nx_nxt = x_in;
        nz_nxt = z_in;
      end else begin
        rx_nxt = rx_r[s == 0 ? 0 : s-1];
        rz_nxt = rz_r[s == 0 ? 0 : s-1];
        nx_nxt = nx_r[s == 0 ? 0 : s-1];
        nz_nxt = nz_r[s == 0 ? 0 : s-1];
      end
      for (int k = 0; k < hbs_pkg::STEPS_PER_ST; k++) begin
        {rx_nxt, nx_nxt} = hbs_pkg::div_step(rx_nxt, nx_nxt, dvs);
        {rz_nxt, nz_nxt} = hbs_pkg::div_step(rz_nxt, nz_nxt, dvs);
      end
    end

    // stage registers
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[s].valid <= 1'b0;
      end else if (adv) begin
        side_r[s] <= (s == 0) ? side_in : side_r[s == 0 ? 0 : s-1];
      end
      if (adv) begin
        rx_r[s] <= rx_nxt;
        rz_r[s] <= rz_nxt;
        nx_r[s] <= nx_nxt;
        nz_r[s] <= nz_nxt;
      end
    end
  end

  assign side_out = side_r[hbs_pkg::DIV_STAGES-1];
  assign gx       = nx_r[hbs_pkg::DIV_STAGES-1];
  assign gz       = nz_r[hbs_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/hbs_map_mem.sv =====
// neighbor addressing, height store (four read copies) and weight products
// depends on hbs_pkg
module hbs_map_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  hbs_pkg::side_t            side_in,
  input  logic [hbs_pkg::POS_W-1:0] gx,
  input  logic [hbs_pkg::POS_W-1:0] gz,
  output hbs_pkg::blend_in_t        blend_out
);

  localparam int CELL_W = hbs_pkg::POS_W - hbs_pkg::FRAC_W;

  logic [CELL_W-1:0]        col0, row0;
  logic [hbs_pkg::IDX_W-1:0] c0, r0, c1, r1;
  logic                     oor_nxt;

  hbs_pkg::side_t                       a_side_r;
  logic                                 a_oor_r;
  logic [hbs_pkg::FRAC_W-1:0]           a_fx_r, a_fz_r;
  logic [3:0][hbs_pkg::ADDR_W-1:0]      a_addr_r, addr_nxt;

  logic [hbs_pkg::FRAC_W:0]             ix, iz, fx9, fz9;

  logic [hbs_pkg::HGT_W-1:0] mem0 [hbs_pkg::STORE_DEPTH];
  logic [hbs_pkg::HGT_W-1:0] mem1 [hbs_pkg::STORE_DEPTH];
  logic [hbs_pkg::HGT_W-1:0] mem2 [hbs_pkg::STORE_DEPTH];
  logic [hbs_pkg::HGT_W-1:0] mem3 [hbs_pkg::STORE_DEPTH];

  logic                                 m_valid_r, m_oor_r;
  logic [3:0][hbs_pkg::HGT_W-1:0]       m_h_r;
  logic [3:0][hbs_pkg::WGT_W-1:0]       m_w_r;
  logic                                 wr_en;

  // base cell, range check and wrapped neighbors
  always_comb begin
    col0    = gx[hbs_pkg::POS_W-1:hbs_pkg::FRAC_W];
    row0    = gz[hbs_pkg::POS_W-1:hbs_pkg::FRAC_W];
    oor_nxt = (col0 >= CELL_W'(hbs_pkg::MAP_SIZE)) || (row0 >= CELL_W'(hbs_pkg::MAP_SIZE));
    c0      = col0[hbs_pkg::IDX_W-1:0];
    r0      = row0[hbs_pkg::IDX_W-1:0];
    c1      = (c0 == hbs_pkg::IDX_W'(hbs_pkg::MAP_SIZE - 1)) ? '0 : c0 + 1'b1;
    r1      = (r0 == hbs_pkg::IDX_W'(hbs_pkg::MAP_SIZE - 1)) ? '0 : r0 + 1'b1;
    addr_nxt[0] = hbs_pkg::ADDR_W'(32'(r0) * 32'(hbs_pkg::MAP_SIZE) + 32'(c0));
    addr_nxt[1] = hbs_pkg::ADDR_W'(32'(r0) * 32'(hbs_pkg::MAP_SIZE) + 32'(c1));
    addr_nxt[2] = hbs_pkg::ADDR_W'(32'(r1) * 32'(hbs_pkg::MAP_SIZE) + 32'(c0));
    addr_nxt[3] = hbs_pkg::ADDR_W'(32'(r1) * 32'(hbs_pkg::MAP_SIZE) + 32'(c1));
  end

  // address stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_side_r.valid <= 1'b0;
    end else if (adv) begin
      a_side_r <= side_in;
    end
    if (adv) begin
      a_oor_r  <= oor_nxt;
      a_fx_r   <= gx[hbs_pkg::FRAC_W-1:0];
      a_fz_r   <= gz[hbs_pkg::FRAC_W-1:0];
      a_addr_r <= addr_nxt;
    end
  end

  // fraction complements
  assign fx9 = {1'b0, a_fx_r};
  assign fz9 = {1'b0, a_fz_r};
  assign ix  = (hbs_pkg::FRAC_W+1)'(1 << hbs_pkg::FRAC_W) - fx9;
  assign iz  = (hbs_pkg::FRAC_W+1)'(1 << hbs_pkg::FRAC_W) - fz9;

  // writes take effect in order with samples at this stage
  assign wr_en = adv && a_side_r.valid && (a_side_r.kind == hbs_pkg::KIND_WRITE);

  // height store copies, one read port each
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem0[a_side_r.idx] <= a_side_r.hgt;
      mem1[a_side_r.idx] <= a_side_r.hgt;
      mem2[a_side_r.idx] <= a_side_r.hgt;
      mem3[a_side_r.idx] <= a_side_r.hgt;
    end
    if (adv) begin
      m_h_r[0] <= mem0[a_addr_r[0]];
      m_h_r[1] <= mem1[a_addr_r[1]];
      m_h_r[2] <= mem2[a_addr_r[2]];
      m_h_r[3] <= mem3[a_addr_r[3]];
    end
  end

  // weights and sample valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r <= a_side_r.valid && (a_side_r.kind == hbs_pkg::KIND_SAMPLE);
    end
    if (adv) begin
      m_oor_r  <= a_oor_r;
      m_w_r[0] <= hbs_pkg::WGT_W'(ix * iz);
      m_w_r[1] <= hbs_pkg::WGT_W'(fx9 * iz);
      m_w_r[2] <= hbs_pkg::WGT_W'(ix * fz9);
      m_w_r[3] <= hbs_pkg::WGT_W'(fx9 * fz9);
    end
  end

  assign blend_out.valid = m_valid_r;
  assign blend_out.oor   = m_oor_r;
  assign blend_out.h     = m_h_r;
  assign blend_out.w     = m_w_r;

endmodule

// ===== rtl/hbs_blend.sv =====
// weighted products, sum and gain scaling into the output register
// depends on hbs_pkg
module hbs_blend (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  hbs_pkg::blend_in_t        blend_in,
  input  logic [hbs_pkg::CFG_W-1:0] height_gain,
  output logic                      out_valid,
  output logic [hbs_pkg::POS_W-1:0] out_height,
  output logic                      out_oor
);

  localparam int ACC_W = 32;
  localparam int SCL_W = ACC_W + hbs_pkg::CFG_W;

  logic                  p_valid_r, p_oor_r;
  logic [3:0][ACC_W-1:0] p_r;
  logic                  s_valid_r, s_oor_r;
  logic [ACC_W-1:0]      s_acc_r;
  logic [SCL_W-1:0]      scaled;
  logic                  o_valid_r, o_oor_r;
  logic [hbs_pkg::POS_W-1:0] o_height_r;

  // per-corner products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r <= blend_in.valid;
    end
    if (adv) begin
      p_oor_r <= blend_in.oor;
      for (int i = 0; i < 4; i++) begin
        p_r[i] <= ACC_W'(blend_in.h[i] * blend_in.w[i]);
      end
    end
  end

  // weights sum to one, so the total stays below 2^32
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (adv) begin
      s_valid_r <= p_valid_r;
    end
    if (adv) begin
      s_oor_r <= p_oor_r;
      s_acc_r <= p_r[0] + p_r[1] + p_r[2] + p_r[3];
    end
  end

  // gain and output register
  assign scaled = SCL_W'(s_acc_r) * SCL_W'(height_gain);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (adv) begin
      o_valid_r <= s_valid_r;
    end
    if (adv) begin
      o_oor_r    <= s_oor_r;
      o_height_r <= s_oor_r ? '0 : scaled[SCL_W-1:hbs_pkg::CFG_W];
    end
  end

  assign out_valid  = o_valid_r;
  assign out_height = o_height_r;
  assign out_oor    = o_oor_r;

endmodule

// ===== rtl/heightmap_bilinear_sampler_unit.sv =====
// top level of the height map bilinear sampler: config registers, handshake, pipeline
// depends on hbs_pkg, hbs_div_pipe, hbs_map_mem, hbs_blend
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/in_stall| kind, entry_index, entry_height, x_pos, z_pos
//  out_    | output    | out_valid/stall  | height, out_of_range
//  config  | input     | psel/penable     | cell_size (0x0), height_gain (0x4)
//
// one item enters per cycle unless the pipeline holds; a sample passes through
// 16 divider stages of two quotient bits, then address, store read, products, sum and gain
// write items update the store at the read stage and give no result
// the whole pipeline holds while a result waits under out_stall
// reset clears valid bits and sets the config registers to 50 and 175; the store is not cleared
module heightmap_bilinear_sampler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_entry_index,
  input  logic [15:0] in_entry_height,
  input  logic [31:0] in_x_pos,
  input  logic [31:0] in_z_pos,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_height,
  output logic        out_out_of_range,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                      adv;
  logic [hbs_pkg::CFG_W-1:0] cell_size_r, height_gain_r;
  hbs_pkg::reg_idx_t         reg_sel;
  hbs_pkg::side_t            side_in, side_div;
  logic [31:0]               gx, gz;
  hbs_pkg::blend_in_t        blend;

  // pipeline advances unless a result waits
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // config registers
  assign pready  = 1'b1;
  assign reg_sel = hbs_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r   <= hbs_pkg::CFG_W'(50);
      height_gain_r <= hbs_pkg::CFG_W'(175);
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        hbs_pkg::REG_CELL_SIZE:   cell_size_r   <= pwdata[hbs_pkg::CFG_W-1:0];
        hbs_pkg::REG_HEIGHT_GAIN: height_gain_r <= pwdata[hbs_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      hbs_pkg::REG_CELL_SIZE:   prdata = {16'b0, cell_size_r};
      hbs_pkg::REG_HEIGHT_GAIN: prdata = {16'b0, height_gain_r};
      default:                  prdata = '0;
    endcase
  end

  // input transfer enters the divider pipeline
  assign side_in.valid = in_valid;
  assign side_in.kind  = in_kind;
  assign side_in.idx   = in_entry_index;
  assign side_in.hgt   = in_entry_height;

  hbs_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .side_in   (side_in),
    .x_in      (in_x_pos),
    .z_in      (in_z_pos),
    .cell_size (cell_size_r),
    .side_out  (side_div),
    .gx        (gx),
    .gz        (gz)
  );

  hbs_map_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .side_in   (side_div),
    .gx        (gx),
    .gz        (gz),
    .blend_out (blend)
  );

  hbs_blend u_blend (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .blend_in    (blend),
    .height_gain (height_gain_r),
    .out_valid   (out_valid),
    .out_height  (out_height),
    .out_oor     (out_out_of_range)
  );

endmodule

// ===== rtl/hbs_checker.sv =====
// port-level checks for the height map sampler, bound to the top level
// depends on heightmap_bilinear_sampler_unit
module hbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_height,
  input logic        out_out_of_range
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_height) && $stable(out_out_of_range))
    else $error("result changed while stalled");

  // input stalls only behind a waiting result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // out of range results carry zero height
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_height == 32'd0)
    else $error("out of range result with nonzero height");

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind heightmap_bilinear_sampler_unit hbs_checker u_hbs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_height       (out_height),
  .out_out_of_range (out_out_of_range)
);

// ===== sim/heightmap_bilinear_sampler_unit_test.sv =====
// self-checking testbench for heightmap_bilinear_sampler_unit: directed table, then random traffic
// depends on hbs_pkg and the heightmap_bilinear_sampler_unit rtl
module heightmap_bilinear_sampler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  IDLE_PCT    = 26;
  localparam int  ITEM_GOAL   = 1850;
  localparam int  HOLD_CYCLES = 300;
  localparam int  DRAIN_GAP   = 30;
  localparam int  CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [31:0] height;
    logic        oor;
  } sample_t;

  typedef struct {
    logic        kind;
    logic [15:0] idx;
    logic [15:0] hgt;
    logic [31:0] x;
    logic [31:0] z;
    bit          typed;
    sample_t     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = hbs_pkg::KIND_WRITE;
  logic [15:0] in_entry_index = '0;
  logic [15:0] in_entry_height = '0;
  logic [31:0] in_x_pos = '0;
  logic [31:0] in_z_pos = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_height;
  logic        out_out_of_range;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  heightmap_bilinear_sampler_unit dut (.*);

  // shadow copy of the block state
  logic [15:0] map_mem [0:hbs_pkg::STORE_DEPTH-1];
  bit          map_set [0:hbs_pkg::STORE_DEPTH-1];
  logic [15:0] cell_size   = 16'd50;
  logic [15:0] height_gain = 16'd175;

  sample_t pending_heights[$];
  int      errors = 0;
  int      items_sent = 0;
  int      writes_sent = 0;
  int      samples_checked = 0;
  int      oor_seen = 0;
  int      cycles = 0;
  bit      quiet = 1'b0;
  bit      hold_req = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_left = 0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // result checker
  always @(posedge clk) begin
    sample_t exp_s;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_heights.size() == 0) begin
        $display("%0t: unexpected result height=%h oor=%b", $time, out_height,
                 out_out_of_range);
        errors++;
      end else begin
        exp_s = pending_heights.pop_front();
        samples_checked++;
        if (out_out_of_range) oor_seen++;
        if (out_height !== exp_s.height) begin
          $display("%0t: height expected %h actual %h", $time, exp_s.height, out_height);
          errors++;
        end
        if (out_out_of_range !== exp_s.oor) begin
          $display("%0t: out_of_range expected %b actual %b", $time, exp_s.oor,
                   out_out_of_range);
          errors++;
        end
      end
    end
  end

  // grid base and fraction of one coordinate
  function automatic void split_coord(input logic [31:0] pos, output logic [31:0] base,
                                      output logic [31:0] frac);
    logic [31:0] dvs;
    logic [31:0] g;
    dvs  = (cell_size == 0) ? 32'd1 : 32'(cell_size);
    g    = pos / dvs;
    base = g >> 8;
    frac = g & 32'hFF;
  endfunction

  function automatic logic [15:0] map_addr(input logic [31:0] row, input logic [31:0] col);
    return 16'(row * hbs_pkg::MAP_SIZE + col);
  endfunction

  function automatic logic [31:0] wrap_next(input logic [31:0] v);
    return (v + 1 >= hbs_pkg::MAP_SIZE) ? 32'd0 : v + 1;
  endfunction

  // bilinear blend scaled by the gain
  function automatic sample_t predict_height(input logic [31:0] x, input logic [31:0] z);
    logic [31:0] c0, r0, c1, r1, fx, fz, ix, iz;
    logic [63:0] acc;
    sample_t     s;
    split_coord(x, c0, fx);
    split_coord(z, r0, fz);
    if (c0 >= hbs_pkg::MAP_SIZE || r0 >= hbs_pkg::MAP_SIZE) begin
      s.height = '0;
      s.oor    = 1'b1;
      return s;
    end
    c1  = wrap_next(c0);
    r1  = wrap_next(r0);
    ix  = 256 - fx;
    iz  = 256 - fz;
    acc = 64'(map_mem[map_addr(r0, c0)]) * 64'(ix * iz)
        + 64'(map_mem[map_addr(r0, c1)]) * 64'(fx * iz)
        + 64'(map_mem[map_addr(r1, c0)]) * 64'(ix * fz)
        + 64'(map_mem[map_addr(r1, c1)]) * 64'(fx * fz);
    s.height = 32'((acc * 64'(height_gain)) >> 16);
    s.oor    = 1'b0;
    return s;
  endfunction

  // offer one item and wait for its transfer
  task automatic send_item(input logic k, input logic [15:0] idx, input logic [15:0] hgt,
                           input logic [31:0] x, input logic [31:0] z, input bit typed,
                           input sample_t want);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= k;
    in_entry_index  <= idx;
    in_entry_height <= hgt;
    in_x_pos        <= x;
    in_z_pos        <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (k == hbs_pkg::KIND_WRITE) begin
      map_mem[idx] = hgt;
      map_set[idx] = 1'b1;
      writes_sent++;
    end else begin
      pending_heights.push_back(typed ? want : predict_height(x, z));
    end
  endtask

  // sample, loading any neighbour that was never written first
  task automatic send_sample(input logic [31:0] x, input logic [31:0] z, input bit typed,
                             input sample_t want);
    logic [31:0] c0, r0, fx, fz;
    logic [15:0] nb [4];
    split_coord(x, c0, fx);
    split_coord(z, r0, fz);
    if (c0 < hbs_pkg::MAP_SIZE && r0 < hbs_pkg::MAP_SIZE) begin
      nb[0] = map_addr(r0, c0);
      nb[1] = map_addr(r0, wrap_next(c0));
      nb[2] = map_addr(wrap_next(r0), c0);
      nb[3] = map_addr(wrap_next(r0), wrap_next(c0));
      foreach (nb[i])
        if (!map_set[nb[i]])
          send_item(hbs_pkg::KIND_WRITE, nb[i], 16'($urandom), '0, '0, 1'b0, '0);
    end
    send_item(hbs_pkg::KIND_SAMPLE, 16'($urandom), 16'($urandom), x, z, typed, want);
  endtask

  // wait for every result, then let the pipeline empty
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // setup and access cycle of one register write
  task automatic write_reg(input hbs_pkg::reg_idx_t r, input logic [15:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {r, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == hbs_pkg::REG_CELL_SIZE) cell_size = val;
    else height_gain = val;
  endtask

  // world coordinate that lands on a chosen cell and fraction
  function automatic logic [31:0] coord_for(input logic [31:0] base);
    logic [31:0] dvs;
    dvs = (cell_size == 0) ? 32'd1 : 32'(cell_size);
    return (base * 256 + $urandom_range(0, 255)) * dvs + $urandom_range(0, dvs - 1);
  endfunction

  function automatic logic [31:0] pick_base;
    if ($urandom_range(0, 99) < 70)
      return $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(248, 255);
    return $urandom_range(0, hbs_pkg::MAP_SIZE - 1);
  endfunction

  // random traffic: mostly in-map samples, some raw coordinates and loose writes
  task automatic random_phase(input int count);
    int pick;
    repeat (count) begin
      if (items_sent >= ITEM_GOAL) break;
      pick = $urandom_range(0, 99);
      if (pick < 15)
        send_item(hbs_pkg::KIND_WRITE, 16'($urandom), 16'($urandom), $urandom, $urandom,
                  1'b0, '0);
      else if (pick < 30)
        send_sample($urandom, $urandom, 1'b0, '0);
      else
        send_sample(coord_for(pick_base()), coord_for(pick_base()), 1'b0, '0);
    end
  endtask

  stim_row_t directed [$];
  int        n_phase;

  initial begin
    // directed rows at reset config (cell 50, gain 175)
    directed = '{
      '{hbs_pkg::KIND_WRITE, 16'd0, 16'hFFFF, 0, 0, 0, '0},
      '{hbs_pkg::KIND_WRITE, 16'd1, 16'hFFFF, 0, 0, 0, '0},
      '{hbs_pkg::KIND_WRITE, 16'd256, 16'hFFFF, 0, 0, 0, '0},
      '{hbs_pkg::KIND_WRITE, 16'd257, 16'hFFFF, 0, 0, 0, '0},
      '{hbs_pkg::KIND_SAMPLE, 0, 0, 32'd0, 32'd0, 1, '{32'd11468625, 1'b0}},
      '{hbs_pkg::KIND_SAMPLE, 0, 0, 32'hFFFFFFFF, 32'd0, 1, '{32'd0, 1'b1}},
      '{hbs_pkg::KIND_SAMPLE, 0, 0, 32'd0, 32'hFFFFFFFF, 1, '{32'd0, 1'b1}},
      '{hbs_pkg::KIND_SAMPLE, 0, 0, 32'd3276800, 32'd0, 1, '{32'd0, 1'b1}},
      '{hbs_pkg::KIND_SAMPLE, 0, 0, 32'd0, 32'd3276800, 1, '{32'd0, 1'b1}},
      // column wrap, row wrap and corner wrap
      '{hbs_pkg::KIND_WRITE, 16'd255, 16'h1234, 0, 0, 0, '0},
      '{hbs_pkg::KIND_WRITE, 16'd511, 16'h8001, 0, 0, 0, '0},
      '{hbs_pkg::KIND_SAMPLE, 0, 0, 32'd3270400, 32'd0, 0, '0},
      '{hbs_pkg::KIND_WRITE, 16'd65280, 16'h0F0F, 0, 0, 0, '0},
      '{hbs_pkg::KIND_WRITE, 16'd65281, 16'hF0F0, 0, 0, 0, '0},
      '{hbs_pkg::KIND_SAMPLE, 0, 0, 32'd0, 32'd3267200, 0, '0},
      '{hbs_pkg::KIND_WRITE, 16'd65535, 16'h0000, 0, 0, 0, '0},
      '{hbs_pkg::KIND_SAMPLE, 0, 0, 32'd3274000, 32'd3274000, 0, '0},
      // last in-map position and the full fraction
      '{hbs_pkg::KIND_SAMPLE, 0, 0, 32'd3276799, 32'd3276799, 0, '0},
      '{hbs_pkg::KIND_SAMPLE, 0, 0, 32'd3276799, 32'd0, 0, '0},
      '{hbs_pkg::KIND_WRITE, 16'd0, 16'h0000, 0, 0, 0, '0},
      '{hbs_pkg::KIND_SAMPLE, 0, 0, 32'd0, 32'd0, 1, '{32'd0, 1'b0}}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == hbs_pkg::KIND_WRITE)
        send_item(hbs_pkg::KIND_WRITE, directed[i].idx, directed[i].hgt, '0, '0, 1'b0, '0);
      else
        send_sample(directed[i].x, directed[i].z, directed[i].typed, directed[i].want);
    end
    drain();

    // config phases, extremes first, then random settings
    n_phase = 0;
    while (items_sent < ITEM_GOAL) begin
      case (n_phase)
        0: begin
          write_reg(hbs_pkg::REG_CELL_SIZE, 16'd1);
          write_reg(hbs_pkg::REG_HEIGHT_GAIN, 16'd1);
        end
        1: begin
          write_reg(hbs_pkg::REG_CELL_SIZE, 16'd65535);
          write_reg(hbs_pkg::REG_HEIGHT_GAIN, 16'd65535);
        end
        2: begin
          write_reg(hbs_pkg::REG_CELL_SIZE, 16'd0);
          write_reg(hbs_pkg::REG_HEIGHT_GAIN, 16'd65535);
        end
        3: begin
          write_reg(hbs_pkg::REG_CELL_SIZE, 16'd65535);
          write_reg(hbs_pkg::REG_HEIGHT_GAIN, 16'd0);
        end
        default: begin
          write_reg(hbs_pkg::REG_CELL_SIZE, 16'($urandom_range(1, 400)));
          write_reg(hbs_pkg::REG_HEIGHT_GAIN, 16'($urandom));
        end
      endcase
      quiet = (n_phase == 2);
      if (n_phase == 1) hold_req <= 1'b1;
      random_phase(250);
      drain();
      quiet = 1'b0;
      n_phase++;
    end

    $display("%0d items sent (%0d writes), %0d samples checked, %0d outside the map",
             items_sent, writes_sent, samples_checked, oor_seen);
    $display("%0d register settings after reset, one long receiver hold-off", n_phase);
    if (errors == 0 && pending_heights.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== heightmap_bilinear_sampler_unit.f =====
rtl/hbs_pkg.sv
rtl/hbs_div_pipe.sv
rtl/hbs_map_mem.sv
rtl/hbs_blend.sv
rtl/heightmap_bilinear_sampler_unit.sv
rtl/hbs_checker.sv
sim/heightmap_bilinear_sampler_unit_test.sv
